// ===== rtl/fwtp_pkg.sv =====
// shared constants, types and microcode table for the factored weight table product
package fwtp_pkg;

  // fixed geometry
  localparam int SQUARE_COUNT   = 64;
  localparam int RANKS          = 8;
  localparam int PIECE_TYPES    = 6;
  localparam int DIVISOR        = 127;
  localparam int EMBED_DIM_DEF  = 6;
  localparam int HIDDEN_DIM_DEF = 10;

  // port field widths
  localparam int KIND_W    = 2;
  localparam int WIDX_W    = 9;
  localparam int WVAL_W    = 8;
  localparam int COLOR_W   = 1;
  localparam int PIECE_W   = 3;
  localparam int SQUARE_W  = 6;
  localparam int OIDX_W    = 4;
  localparam int S1_OUT_W  = 11;
  localparam int FIN_OUT_W = 14;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_SQ  = 2'd0,
    KIND_LOAD_PC  = 2'd1,
    KIND_LOAD_COL = 2'd2,
    KIND_QUERY    = 2'd3
  } kind_t;

  // microprogram step addresses
  typedef enum logic [3:0] {
    UP_IDLE,
    UP_HEAD,
    UP_MAC,
    UP_DIV1,
    UP_DIV2,
    UP_MAC2,
    UP_FDIV1,
    UP_FDIV2,
    UP_EMIT
  } upc_t;

  // stage-one accumulator control
  typedef enum logic [1:0] {
    A1_HOLD,
    A1_CLR,
    A1_MAC
  } acc1_op_t;

  // table pointer control
  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ADV,
    PTR_ADV_LOOP,
    PTR_REWIND
  } ptr_op_t;

  // loop counter control
  typedef enum logic [1:0] {
    CNT_NONE,
    CNT_D_CLR,
    CNT_D_INC,
    CNT_H_INC
  } cnt_op_t;

  // reciprocal divider control
  typedef enum logic [2:0] {
    DV_NONE,
    DV_MUL_S1,
    DV_MUL_FIN,
    DV_FIX,
    DV_FIX_S1
  } div_op_t;

  // sequencer branch control
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_D_LOOP,
    JMP_H_LOOP,
    JMP_DISPATCH
  } jmp_op_t;

  // one control word
  typedef struct packed {
    acc1_op_t acc1;
    ptr_op_t  ptr;
    cnt_op_t  cnt;
    div_op_t  div;
    logic     fin_mac;
    logic     emit;
    jmp_op_t  jmp;
    upc_t     target;
  } cw_t;

  // microcode rom
  function automatic cw_t ucode(upc_t step);
    cw_t cw;
    cw.acc1    = A1_HOLD;
    cw.ptr     = PTR_HOLD;
    cw.cnt     = CNT_NONE;
    cw.div     = DV_NONE;
    cw.fin_mac = 1'b0;
    cw.emit    = 1'b0;
    cw.jmp     = JMP_NEXT;
    cw.target  = UP_IDLE;
    case (step)
      UP_IDLE: begin
        cw.jmp = JMP_DISPATCH;
      end
      UP_HEAD: begin
        cw.acc1 = A1_CLR;
        cw.ptr  = PTR_ADV;
        cw.cnt  = CNT_D_CLR;
      end
      UP_MAC: begin
        cw.acc1   = A1_MAC;
        cw.ptr    = PTR_ADV_LOOP;
        cw.cnt    = CNT_D_INC;
        cw.jmp    = JMP_D_LOOP;
        cw.target = UP_MAC;
      end
      UP_DIV1: begin
        cw.div = DV_MUL_S1;
        cw.ptr = PTR_REWIND;
      end
      UP_DIV2: begin
        cw.div = DV_FIX_S1;
      end
      UP_MAC2: begin
        cw.fin_mac = 1'b1;
        cw.cnt     = CNT_H_INC;
        cw.jmp     = JMP_H_LOOP;
        cw.target  = UP_HEAD;
      end
      UP_FDIV1: begin
        cw.div = DV_MUL_FIN;
      end
      UP_FDIV2: begin
        cw.div = DV_FIX;
      end
      UP_EMIT: begin
        cw.emit   = 1'b1;
        cw.jmp    = JMP_ALWAYS;
        cw.target = UP_IDLE;
      end
      default: begin
        cw.jmp    = JMP_ALWAYS;
        cw.target = UP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/factored_weight_table_product_top.sv =====
// factored weight table product: weight tables, microcoded sequencer and datapath
//
// Loads (kind 0..2) write one weight byte in the cycle they are accepted and leave busy low.
// A query holds busy high through its emit step, and its result strobes on out_valid for one
// cycle right after busy drops; a query with an out-of-range piece or output index goes
// straight to the emit step and returns zeros. Each of the HIDDEN_DIM stage-one values is
// summed by the single 8x8 multiply-add, which takes one embedding term per cycle, and is
// followed by the two-step reciprocal divide by 127 after each sum.
// The receiver cannot stall: sample out_* whenever out_valid is high.
module factored_weight_table_product_top #(
  parameter int EMBED_DIM  = fwtp_pkg::EMBED_DIM_DEF,
  parameter int HIDDEN_DIM = fwtp_pkg::HIDDEN_DIM_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [fwtp_pkg::KIND_W-1:0]            in_kind,
  input  logic [fwtp_pkg::WIDX_W-1:0]            in_weight_index,
  input  logic signed [fwtp_pkg::WVAL_W-1:0]     in_weight_value,
  input  logic [fwtp_pkg::COLOR_W-1:0]           in_color,
  input  logic [fwtp_pkg::PIECE_W-1:0]           in_piece,
  input  logic [fwtp_pkg::SQUARE_W-1:0]          in_square,
  input  logic [fwtp_pkg::OIDX_W-1:0]            in_output_index,
  output logic                                   out_valid,
  output logic signed [fwtp_pkg::S1_OUT_W-1:0]   out_stage_one_value,
  output logic signed [fwtp_pkg::FIN_OUT_W-1:0]  out_final_value
);
  import fwtp_pkg::*;

  // table geometry
  localparam int RANK_BYTES = EMBED_DIM * 8;
  localparam int SQ_DEPTH   = SQUARE_COUNT * EMBED_DIM;
  localparam int PC_DEPTH   = HIDDEN_DIM * EMBED_DIM * PIECE_TYPES;
  localparam int COL_DEPTH  = HIDDEN_DIM * HIDDEN_DIM * 2;
  localparam int SQ_AW      = $clog2(SQ_DEPTH);
  localparam int PC_AW      = (PC_DEPTH > 1) ? $clog2(PC_DEPTH) : 1;
  localparam int COL_AW     = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
  localparam int D_W        = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
  localparam int H_W        = (HIDDEN_DIM > 1) ? $clog2(HIDDEN_DIM) : 1;

  // arithmetic widths
  localparam int SUM1_W = $clog2(EMBED_DIM) + 16;
  localparam int S1_W   = SUM1_W - 6;
  localparam int ACC_W  = S1_W + 8 + $clog2(HIDDEN_DIM);
  localparam int Q_W    = ACC_W - 6;
  localparam int RECIP  = (2 ** ACC_W) / DIVISOR;
  localparam int MUL2_W = S1_W + 8;
  localparam int PROD_W = ACC_W + Q_W;

  // control
  upc_t upc_r, upc_nxt;
  cw_t  cw;
  logic accept, is_query, query_ok, loop_take, d_last, h_last, out_valid_r;

  // datapath registers
  logic [SQ_AW-1:0]           sq_base_r, sq_ptr_r;
  logic [PC_AW-1:0]           pc_ptr_r;
  logic [COL_AW-1:0]          col_ptr_r;
  logic [D_W-1:0]             d_r;
  logic [H_W-1:0]             h_r, oidx_r;
  logic                       zero_r;
  logic signed [SUM1_W-1:0]   acc1_r;
  logic signed [ACC_W-1:0]    fin_r;
  logic [ACC_W+Q_W-1:0]       div_prod_r;
  logic [ACC_W-1:0]           div_mag_r;
  logic                       div_neg_r;
  logic signed [Q_W:0]        q_r;
  logic signed [S1_W-1:0]     s1_keep_r;
  logic signed [S1_OUT_W-1:0] out_s1_r;
  logic signed [FIN_OUT_W-1:0] out_fin_r;

  // memories and registered read data
  logic signed [WVAL_W-1:0] sq_mem  [SQ_DEPTH];
  logic signed [WVAL_W-1:0] pc_mem  [PC_DEPTH];
  logic signed [WVAL_W-1:0] col_mem [COL_DEPTH];
  logic signed [WVAL_W-1:0] sq_rd_r, pc_rd_r, col_rd_r;

  // combinational datapath values
  logic [2:0]               ld_rank;
  logic [SQ_AW-1:0]         sq_wr_addr;
  logic                     sq_we, pc_we, col_we;
  logic signed [15:0]       mul1;
  logic signed [S1_W-1:0]   q_s1;
  logic signed [S1_W+7:0]   mul2;
  logic signed [ACC_W-1:0]  div_src;
  logic                     div_neg;
  logic [ACC_W-1:0]         div_mag;
  logic [ACC_W+Q_W-1:0]     div_prod;
  logic [Q_W-1:0]           q_est, q_mag;
  logic [ACC_W-1:0]         q_back, q_rem;
  logic signed [Q_W:0]      q_fix;

  assign busy      = (upc_r != UP_IDLE);
  assign accept    = start && !busy;
  assign is_query  = (in_kind == KIND_QUERY);
  assign query_ok  = (int'(in_piece) < PIECE_TYPES) && (int'(in_output_index) < HIDDEN_DIM);
  assign cw        = ucode(upc_r);
  assign d_last    = (d_r == D_W'(EMBED_DIM - 1));
  assign h_last    = (h_r == H_W'(HIDDEN_DIM - 1));
  assign out_valid = out_valid_r;
  assign out_stage_one_value = out_s1_r;
  assign out_final_value     = out_fin_r;

  // rank mirror of square table loads
  always_comb begin
    ld_rank = '0;
    for (int k = 1; k < RANKS; k++) begin
      if (int'(in_weight_index) >= k * RANK_BYTES) begin
        ld_rank = 3'(ld_rank + 3'd1);
      end
    end
    sq_wr_addr = SQ_AW'(int'(in_weight_index) + (RANKS - 1 - 2 * int'(ld_rank)) * RANK_BYTES);
  end

  // load write enables
  assign sq_we  = accept && (in_kind == KIND_LOAD_SQ)  && (int'(in_weight_index) < SQ_DEPTH);
  assign pc_we  = accept && (in_kind == KIND_LOAD_PC)  && (int'(in_weight_index) < PC_DEPTH);
  assign col_we = accept && (in_kind == KIND_LOAD_COL) && (int'(in_weight_index) < COL_DEPTH);

  // weight tables, one write and one registered read each
  always_ff @(posedge clk) begin
    if (sq_we) begin
      sq_mem[sq_wr_addr] <= in_weight_value;
    end
    sq_rd_r <= sq_mem[sq_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (pc_we) begin
      pc_mem[PC_AW'(in_weight_index)] <= in_weight_value;
    end
    pc_rd_r <= pc_mem[pc_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[COL_AW'(in_weight_index)] <= in_weight_value;
    end
    col_rd_r <= col_mem[col_ptr_r];
  end

  // branch condition and next step
  always_comb begin
    case (cw.jmp)
      JMP_D_LOOP: loop_take = !d_last;
      JMP_H_LOOP: loop_take = !h_last;
      default:    loop_take = 1'b0;
    endcase
    case (cw.jmp)
      JMP_NEXT:   upc_nxt = upc_t'(4'(upc_r + 4'd1));
      JMP_ALWAYS: upc_nxt = cw.target;
      JMP_D_LOOP,
      JMP_H_LOOP: upc_nxt = loop_take ? cw.target : upc_t'(4'(upc_r + 4'd1));
      JMP_DISPATCH: begin
        if (accept && is_query) begin
          upc_nxt = query_ok ? UP_HEAD : UP_EMIT;
        end else begin
          upc_nxt = UP_IDLE;
        end
      end
      default:    upc_nxt = UP_IDLE;
    endcase
  end

  // step counter and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      out_valid_r <= cw.emit;
    end
  end

  // multiply-add operands
  assign mul1 = 16'(sq_rd_r) * 16'(pc_rd_r);
  assign q_s1 = S1_W'(q_r);
  assign mul2 = MUL2_W'(q_s1) * MUL2_W'(col_rd_r);

  // divide by 127: reciprocal multiply, then one compare and correct
  assign div_src  = (cw.div == DV_MUL_FIN) ? fin_r : ACC_W'(acc1_r);
  assign div_neg  = div_src[ACC_W-1];
  assign div_mag  = div_neg ? ACC_W'(-div_src) : ACC_W'(div_src);
  assign div_prod = PROD_W'(div_mag) * PROD_W'(RECIP);
  assign q_est    = div_prod_r[ACC_W +: Q_W];
  assign q_back   = ACC_W'(q_est) * ACC_W'(DIVISOR);
  assign q_rem    = div_mag_r - q_back;
  assign q_mag    = (int'(q_rem) >= DIVISOR) ? Q_W'(q_est + Q_W'(1)) : q_est;
  assign q_fix    = div_neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  // datapath driven by the control word
  always_ff @(posedge clk) begin
    // query setup at transfer
    if (cw.jmp == JMP_DISPATCH && accept && is_query) begin
      sq_base_r <= SQ_AW'(int'(in_square) * EMBED_DIM);
      sq_ptr_r  <= SQ_AW'(int'(in_square) * EMBED_DIM);
      pc_ptr_r  <= PC_AW'(in_piece);
      col_ptr_r <= COL_AW'(int'(in_output_index) * 2 * HIDDEN_DIM + int'(in_color));
      oidx_r    <= H_W'(in_output_index);
      h_r       <= '0;
      fin_r     <= '0;
      zero_r    <= !query_ok;
    end

    // table pointers
    case (cw.ptr)
      PTR_ADV: begin
        sq_ptr_r <= SQ_AW'(sq_ptr_r + SQ_AW'(1));
        pc_ptr_r <= PC_AW'(pc_ptr_r + PC_AW'(PIECE_TYPES));
      end
      PTR_ADV_LOOP: begin
        if (loop_take) begin
          sq_ptr_r <= SQ_AW'(sq_ptr_r + SQ_AW'(1));
          pc_ptr_r <= PC_AW'(pc_ptr_r + PC_AW'(PIECE_TYPES));
        end
      end
      PTR_REWIND: sq_ptr_r <= sq_base_r;
      default: ;
    endcase

    // loop counters
    case (cw.cnt)
      CNT_D_CLR: d_r <= '0;
      CNT_D_INC: d_r <= D_W'(d_r + D_W'(1));
      CNT_H_INC: begin
        h_r       <= H_W'(h_r + H_W'(1));
        col_ptr_r <= COL_AW'(col_ptr_r + COL_AW'(2));
      end
      default: ;
    endcase

    // stage-one accumulator
    case (cw.acc1)
      A1_CLR:  acc1_r <= '0;
      A1_MAC:  acc1_r <= acc1_r + SUM1_W'(mul1);
      default: ;
    endcase

    // divider
    case (cw.div)
      DV_MUL_S1,
      DV_MUL_FIN: begin
        div_prod_r <= div_prod;
        div_mag_r  <= div_mag;
        div_neg_r  <= div_neg;
      end
      DV_FIX: q_r <= q_fix;
      DV_FIX_S1: begin
        q_r <= q_fix;
        if (h_r == oidx_r) begin
          s1_keep_r <= S1_W'(q_fix);
        end
      end
      default: ;
    endcase

    // final accumulator
    if (cw.fin_mac) begin
      fin_r <= fin_r + ACC_W'(mul2);
    end

    // result register
    if (cw.emit) begin
      out_s1_r  <= zero_r ? '0 : S1_OUT_W'(s1_keep_r);
      out_fin_r <= zero_r ? '0 : FIN_OUT_W'(q_r);
    end
  end

endmodule

// ===== rtl/fwtp_checker.sv =====
// port-level checks for the factored weight table product, bound to the top level
module fwtp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [fwtp_pkg::KIND_W-1:0]   in_kind,
  input logic                          out_valid
);
  import fwtp_pkg::*;

  // a query transfer always starts work
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  // a load finishes in its own cycle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind != KIND_QUERY) |=> !busy)
    else $error("load transfer raised busy");

  // results only come out once the sequencer is back at rest
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // one strobe per query, never two in a row
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // reset brings the block to rest
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not at rest after reset");

endmodule

bind factored_weight_table_product_top fwtp_checker u_fwtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_kind   (in_kind),
  .out_valid (out_valid)
);
